[rtl/int32_to_float32_converter_top_macros.svh]
// Assertion macros for the int32 to float32 converter checker.
// No dependencies; included by the checker file only.
`ifndef INT32_TO_FLOAT32_CONVERTER_TOP_MACROS_SVH
`define INT32_TO_FLOAT32_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define I2F_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define I2F_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i2f_pkg.sv]
// Shared constants, stage payload types and the leading-one search for the
// int32 to float32 converter. No dependencies.
package i2f_pkg;

    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;
    localparam int FRAC_BITS = 23;
    localparam int EXP_W    = 8;
    localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;

    typedef struct packed {
        logic              sign;
        logic [WORD_W-1:0] mag;
    } abs_t;

    typedef struct packed {
        logic              sign;
        logic              zero;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] mag;
    } lzd_t;

    typedef struct packed {
        logic              sign;
        logic              zero;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] norm;
    } norm_t;

    // Index of the highest set bit; 0 when no bit is set.
    function automatic logic [POS_W-1:0] lead_one_pos(input logic [WORD_W-1:0] m);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (m[i])
            begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

[rtl/i2f_abs.sv]
// Stage 1: split off the sign and form the magnitude.
// Depends on i2f_pkg.
module i2f_abs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [i2f_pkg::WORD_W-1:0] in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output i2f_pkg::abs_t              out_data
);
    import i2f_pkg::*;

    logic valid_reg;
    abs_t data_reg;
    abs_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.sign = in_data[WORD_W-1];
        data_next.mag  = in_data[WORD_W-1] ? (~in_data + WORD_W'(1)) : in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/i2f_lzd.sv]
// Stage 2: locate the leading one of the magnitude and flag zero.
// Depends on i2f_pkg.
module i2f_lzd (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  i2f_pkg::abs_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output i2f_pkg::lzd_t out_data
);
    import i2f_pkg::*;

    logic valid_reg;
    lzd_t data_reg;
    lzd_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.sign = in_data.sign;
        data_next.zero = (in_data.mag == '0);
        data_next.pos  = lead_one_pos(in_data.mag);
        data_next.mag  = in_data.mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/i2f_norm.sv]
// Stage 3: shift the magnitude left so the leading one sits in the top bit.
// Depends on i2f_pkg.
module i2f_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  i2f_pkg::lzd_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output i2f_pkg::norm_t out_data
);
    import i2f_pkg::*;

    logic  valid_reg;
    norm_t data_reg;
    norm_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.sign = in_data.sign;
        data_next.zero = in_data.zero;
        data_next.pos  = in_data.pos;
        // shift by (WORD_W-1 - pos), which is the bitwise inverse of pos
        data_next.norm = in_data.mag << (~in_data.pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/i2f_round.sv]
// Stage 4: round to nearest even, fold in the carry and pack the result.
// Depends on i2f_pkg.
module i2f_round (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  i2f_pkg::norm_t             in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [i2f_pkg::WORD_W-1:0] out_data
);
    import i2f_pkg::*;

    localparam int SIG_W  = FRAC_BITS + 1;
    localparam int DROP_W = WORD_W - SIG_W;

    logic                valid_reg;
    logic [WORD_W-1:0]   data_reg;
    logic [WORD_W-1:0]   data_next;
    logic [SIG_W-1:0]    keep;
    logic                guard;
    logic                sticky;
    logic                round_up;
    logic [SIG_W:0]      sum;
    logic                carry;
    logic [FRAC_BITS-1:0] frac;
    logic [EXP_W-1:0]    expo;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        keep     = in_data.norm[WORD_W-1:DROP_W];
        guard    = in_data.norm[DROP_W-1];
        sticky   = |in_data.norm[DROP_W-2:0];
        round_up = guard && (sticky || keep[0]);
        sum      = {1'b0, keep} + (SIG_W+1)'(round_up);
        carry    = sum[SIG_W];
        // a carry out leaves the fraction all zero and bumps the exponent
        frac     = carry ? '0 : sum[FRAC_BITS-1:0];
        expo     = EXP_W'(in_data.pos) + EXP_BIAS + EXP_W'(carry);
        data_next = in_data.zero ? '0 : {in_data.sign, expo, frac};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/int32_to_float32_converter_top.sv]
// An accepted input is registered in the abs, lzd, norm and round stages in turn.
// Throughput: one transaction per cycle while m_axis_tready is high; each of the four
// stage registers holds its item while the stage after it is full and stalled.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data is kept.
// Depends on i2f_pkg, i2f_abs, i2f_lzd, i2f_norm and i2f_round.
module int32_to_float32_converter_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [i2f_pkg::WORD_W-1:0] s_axis_tdata,  // [31:0] int_value (signed)
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [i2f_pkg::WORD_W-1:0] m_axis_tdata   // [31:0] float_bits
);
    import i2f_pkg::*;

    logic  abs_valid;
    logic  abs_ready;
    abs_t  abs_data;
    logic  lzd_valid;
    logic  lzd_ready;
    lzd_t  lzd_data;
    logic  norm_valid;
    logic  norm_ready;
    norm_t norm_data;

    i2f_abs u_abs (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (abs_valid),
        .out_ready (abs_ready),
        .out_data  (abs_data)
    );

    i2f_lzd u_lzd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (abs_valid),
        .in_ready  (abs_ready),
        .in_data   (abs_data),
        .out_valid (lzd_valid),
        .out_ready (lzd_ready),
        .out_data  (lzd_data)
    );

    i2f_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lzd_valid),
        .in_ready  (lzd_ready),
        .in_data   (lzd_data),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_data  (norm_data)
    );

    i2f_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

[rtl/i2f_checker.sv]
// Port-level checker for the int32 to float32 converter, bound to the top level.
// Depends on int32_to_float32_converter_top_macros.svh.
`include "int32_to_float32_converter_top_macros.svh"

module i2f_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result holds
    `I2F_ASSERT_NEXT(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata),
        "stalled output transaction changed")

    // a free output drains the whole pipe, so the input side must be open
    `I2F_ASSERT_NOW(a_ready_chain, clk, rst_n,
        m_axis_tready,
        s_axis_tready,
        "input blocked while output ready")

    // a zero exponent only ever comes from a zero input, and zero is positive
    `I2F_ASSERT_NOW(a_zero_exp, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[30:23] == 8'd0),
        m_axis_tdata == 32'd0,
        "zero exponent on a non-zero result")

    // a 32-bit integer never exceeds 2^31
    `I2F_ASSERT_NOW(a_exp_range, clk, rst_n,
        m_axis_tvalid,
        m_axis_tdata[30:23] <= 8'd158,
        "exponent beyond 2^31")

    // 2^31 is reached only with a zero fraction
    `I2F_ASSERT_NOW(a_top_exact, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[30:23] == 8'd158),
        m_axis_tdata[22:0] == 23'd0,
        "fraction set at the top exponent")

endmodule

bind int32_to_float32_converter_top i2f_checker u_i2f_checker (.*);
